>>> rtl/mide_pkg.sv
// Shared types, constants and helper functions for the multi-input debounce block.
// Used by every module in rtl/; it depends on nothing.
package mide_pkg;

    localparam int unsigned CntW = 8;
    localparam int unsigned AddrW = 4;
    localparam int unsigned DataW = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_BODY_ABSENT = 2'd1;
    localparam logic [1:0] REG_BODY_PRESENT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CntW-1:0] DEBOUNCE_RST = 8'd4;
    localparam logic [CntW-1:0] BODY_ABSENT_RST = 8'd12;
    localparam logic [CntW-1:0] BODY_PRESENT_RST = 8'd2;

    // The card light is sampled when the low seven tick bits wrap to zero.
    localparam logic [CntW-1:0] LIGHT_MASK = 8'h7f;

    // Debounced door state codes.
    localparam logic [1:0] DOOR_UNKNOWN = 2'd0;
    localparam logic [1:0] DOOR_IS_OPEN = 2'd1;
    localparam logic [1:0] DOOR_IS_CLOSED = 2'd2;

    typedef struct packed {
        logic [CntW-1:0] debounce_ticks;
        logic [CntW-1:0] body_absent_ticks;
        logic [CntW-1:0] body_present_ticks;
    } t_cfg;

    // One result item; the order puts door_event in the lowest bit when packed.
    typedef struct packed {
        logic light_on;
        logic light_update;
        logic body_present;
        logic body_event;
        logic tamper_event;
        logic unlock_event;
        logic door_now_open;
        logic door_event;
    } t_result;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == {CntW{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

>>> rtl/mide_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on mide_pkg for register indexes, reset values and the t_cfg struct.
module mide_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [mide_pkg::AddrW-1:0]    i_addr,
    input  logic [mide_pkg::DataW-1:0]    i_wdata,
    output logic [mide_pkg::DataW-1:0]    o_rdata,
    output mide_pkg::t_cfg                o_cfg
);

    mide_pkg::t_cfg r_cfg;
    mide_pkg::t_cfg n_cfg;
    logic [1:0]     w_index;

    assign w_index = i_addr[3:2];

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (w_index)
                mide_pkg::REG_DEBOUNCE:
                    n_cfg.debounce_ticks = i_wdata[mide_pkg::CntW-1:0];
                mide_pkg::REG_BODY_ABSENT:
                    n_cfg.body_absent_ticks = i_wdata[mide_pkg::CntW-1:0];
                mide_pkg::REG_BODY_PRESENT:
                    n_cfg.body_present_ticks = i_wdata[mide_pkg::CntW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= mide_pkg::DEBOUNCE_RST;
            r_cfg.body_absent_ticks <= mide_pkg::BODY_ABSENT_RST;
            r_cfg.body_present_ticks <= mide_pkg::BODY_PRESENT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_index)
            mide_pkg::REG_DEBOUNCE:
                o_rdata = {{(mide_pkg::DataW-mide_pkg::CntW){1'b0}}, r_cfg.debounce_ticks};
            mide_pkg::REG_BODY_ABSENT:
                o_rdata = {{(mide_pkg::DataW-mide_pkg::CntW){1'b0}}, r_cfg.body_absent_ticks};
            mide_pkg::REG_BODY_PRESENT:
                o_rdata = {{(mide_pkg::DataW-mide_pkg::CntW){1'b0}}, r_cfg.body_present_ticks};
            default:
                o_rdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/mide_eval.sv
// Per-tick debounce state and the next-result logic for all five inputs.
// Depends on mide_pkg for t_cfg, t_result, the door codes and sat_inc.
module mide_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_command,
    input  logic                i_door_level,
    input  logic                i_lock_switch_level,
    input  logic                i_tamper_level,
    input  logic                i_body_level,
    input  logic                i_photo_level,
    input  mide_pkg::t_cfg      i_cfg,
    output mide_pkg::t_result   o_result
);

    logic [mide_pkg::CntW-1:0] r_door_high_run, n_door_high_run;
    logic [mide_pkg::CntW-1:0] r_door_low_run, n_door_low_run;
    logic [1:0]                r_door_state, n_door_state;
    logic [mide_pkg::CntW-1:0] r_unlock_run, n_unlock_run;
    logic                      r_unlock_armed, n_unlock_armed;
    logic [mide_pkg::CntW-1:0] r_tamper_run, n_tamper_run;
    logic                      r_tamper_latched, n_tamper_latched;
    logic [mide_pkg::CntW-1:0] r_body_high_run, n_body_high_run;
    logic [mide_pkg::CntW-1:0] r_body_low_run, n_body_low_run;
    logic                      r_body_state, n_body_state;
    logic [mide_pkg::CntW-1:0] r_tick_count, n_tick_count;

    always_comb begin
        n_door_high_run = r_door_high_run;
        n_door_low_run = r_door_low_run;
        n_door_state = r_door_state;
        n_unlock_run = r_unlock_run;
        n_unlock_armed = r_unlock_armed;
        n_tamper_run = r_tamper_run;
        n_tamper_latched = r_tamper_latched;
        n_body_high_run = r_body_high_run;
        n_body_low_run = r_body_low_run;
        n_body_state = r_body_state;
        n_tick_count = r_tick_count;
        o_result = '0;

        if (i_command) begin
            // A clear touches only the body sense state and reports nothing.
            n_body_high_run = '0;
            n_body_low_run = '0;
            n_body_state = 1'b0;
        end else begin
            n_tick_count = r_tick_count + 1'b1;
            if ((n_tick_count & mide_pkg::LIGHT_MASK) == '0) begin
                o_result.light_update = 1'b1;
                o_result.light_on = i_photo_level;
            end

            if (i_door_level) begin
                n_door_low_run = '0;
                n_door_high_run = mide_pkg::sat_inc(r_door_high_run);
                if (n_door_high_run >= i_cfg.debounce_ticks) begin
                    if (r_door_state != mide_pkg::DOOR_IS_OPEN) begin
                        o_result.door_event = 1'b1;
                        o_result.door_now_open = 1'b1;
                    end
                    n_door_state = mide_pkg::DOOR_IS_OPEN;
                end
            end else begin
                n_door_high_run = '0;
                n_door_low_run = mide_pkg::sat_inc(r_door_low_run);
                if (n_door_low_run >= i_cfg.debounce_ticks) begin
                    if (r_door_state != mide_pkg::DOOR_IS_CLOSED) begin
                        o_result.door_event = 1'b1;
                    end
                    n_door_state = mide_pkg::DOOR_IS_CLOSED;
                end
            end

            if (!i_lock_switch_level) begin
                n_unlock_run = mide_pkg::sat_inc(r_unlock_run);
                if (n_unlock_run >= i_cfg.debounce_ticks) begin
                    o_result.unlock_event = r_unlock_armed;
                    n_unlock_armed = 1'b0;
                end
            end else begin
                n_unlock_armed = 1'b1;
                n_unlock_run = '0;
            end

            if (!i_tamper_level) begin
                n_tamper_run = mide_pkg::sat_inc(r_tamper_run);
                if (n_tamper_run >= i_cfg.debounce_ticks) begin
                    o_result.tamper_event = !r_tamper_latched;
                    n_tamper_latched = 1'b1;
                end
            end else begin
                n_tamper_latched = 1'b0;
                n_tamper_run = '0;
            end

            if (i_body_level) begin
                n_body_low_run = '0;
                n_body_high_run = mide_pkg::sat_inc(r_body_high_run);
                if (n_body_high_run >= i_cfg.body_absent_ticks) begin
                    o_result.body_event = r_body_state;
                    n_body_state = 1'b0;
                end
            end else begin
                n_body_high_run = '0;
                n_body_low_run = mide_pkg::sat_inc(r_body_low_run);
                if (n_body_low_run >= i_cfg.body_present_ticks) begin
                    if (!r_body_state) begin
                        o_result.body_event = 1'b1;
                        o_result.body_present = 1'b1;
                    end
                    n_body_state = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_high_run <= '0;
            r_door_low_run <= '0;
            r_door_state <= mide_pkg::DOOR_UNKNOWN;
            r_unlock_run <= '0;
            r_unlock_armed <= 1'b0;
            r_tamper_run <= '0;
            r_tamper_latched <= 1'b0;
            r_body_high_run <= '0;
            r_body_low_run <= '0;
            r_body_state <= 1'b0;
            r_tick_count <= '0;
        end else if (i_accept) begin
            r_door_high_run <= n_door_high_run;
            r_door_low_run <= n_door_low_run;
            r_door_state <= n_door_state;
            r_unlock_run <= n_unlock_run;
            r_unlock_armed <= n_unlock_armed;
            r_tamper_run <= n_tamper_run;
            r_tamper_latched <= n_tamper_latched;
            r_body_high_run <= n_body_high_run;
            r_body_low_run <= n_body_low_run;
            r_body_state <= n_body_state;
            r_tick_count <= n_tick_count;
        end
    end

endmodule

>>> rtl/multi_input_debounce_events_core.sv
// Top level of the multi-input debounce and change-event block.
// Depends on mide_pkg, mide_cfg and mide_eval.
//
// Usage:
// The slave stream takes one request per scan tick. tuser carries the command
// (0 scan tick with samples, 1 clear the body sense state); tdata carries the
// five sampled switch and sensor levels. Each request yields exactly one result
// on the master stream, an eight-bit word of event flags and new states.
// The result is loaded into the output register in the cycle after the request is
// accepted. A request can be accepted in every cycle: one per clock is the
// sustained rate, set by the single result register, which is refilled in the
// same cycle that the downstream side takes its contents.
// When the receiver stalls, the result stays in the output register and
// s_axis_tready drops until it is taken; the debounce state only moves on
// accepted requests, so no tick is lost.
// The APB-style port holds three 8-bit thresholds at byte addresses 0, 4 and 8
// (debounce, body absent, body present). Write them only while the block is
// idle. Synchronous reset restores the thresholds to 4, 12 and 2, clears all
// run counters, marks the door state unknown and empties the output register.
module multi_input_debounce_events_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, from bit 0: door_level, lock_switch_level, tamper_level,
    // body_level, photo_level, then three zero bits.
    input  logic [7:0]                    s_axis_tdata,
    // tuser, bit 0: command.
    input  logic                          s_axis_tuser,
    // Master stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata, from bit 0: door_event, door_now_open, unlock_event, tamper_event,
    // body_event, body_present, light_update, light_on.
    output logic [7:0]                    m_axis_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mide_pkg::AddrW-1:0]    paddr,
    input  logic [mide_pkg::DataW-1:0]    pwdata,
    output logic [mide_pkg::DataW-1:0]    prdata,
    output logic                          pready
);

    mide_pkg::t_cfg    w_cfg;
    mide_pkg::t_result w_result;
    mide_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_accept;
    logic              w_cfg_wr;

    // The configuration port never waits.
    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    mide_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_cfg_wr),
        .i_addr  (paddr),
        .i_wdata (pwdata),
        .o_rdata (prdata),
        .o_cfg   (w_cfg)
    );

    // A new request is taken whenever the output register is empty or is
    // being drained in this same cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    mide_eval u_eval (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (w_accept),
        .i_command           (s_axis_tuser),
        .i_door_level        (s_axis_tdata[0]),
        .i_lock_switch_level (s_axis_tdata[1]),
        .i_tamper_level      (s_axis_tdata[2]),
        .i_body_level        (s_axis_tdata[3]),
        .i_photo_level       (s_axis_tdata[4]),
        .i_cfg               (w_cfg),
        .o_result            (w_result)
    );

    // Output register: loaded on every accepted request, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;

    // A clear request always produces an all-zero result in the next cycle.
    a_clear_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser) |=> (m_axis_tvalid && m_axis_tdata == 8'd0))
        else $error("clear request produced a nonzero result");

    // An empty output register must never hold off the slave side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("slave side stalled with an empty output register");

    // The state flags are only set together with their event flags.
    a_state_needs_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((!m_axis_tdata[1] || m_axis_tdata[0])
                        && (!m_axis_tdata[5] || m_axis_tdata[4])
                        && (!m_axis_tdata[7] || m_axis_tdata[6])))
        else $error("state flag set without its event flag");

    // A result that is not taken stays in place for the next cycle.
    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or vanished");

endmodule

>>> tb/mide_tb_pkg.sv
// Command and register codes shared by the debounce block testbench files.
// Depends on nothing; the RTL package is imported separately where needed.
`timescale 1ns / 1ps
package mide_tb_pkg;

    // Command carried in tuser of each request.
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Register index past the end of the map; writes there must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

endpackage

>>> tb/mide_event_checker.sv
// Checker for the multi-input debounce block: watches both streams and the APB port,
// predicts each result and compares it. Depends on mide_pkg and mide_tb_pkg.
`timescale 1ns / 1ps
module mide_event_checker
    import mide_pkg::*;
    import mide_tb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,
    input  logic             s_axis_tuser,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [7:0]       m_axis_tdata,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    input  logic [DataW-1:0] prdata,
    input  logic             pready,
    output int               o_err_count,
    output int               o_pending
);

    t_cfg            thresholds;
    logic [CntW-1:0] door_ajar_run;
    logic [CntW-1:0] door_shut_run;
    logic [1:0]      door_seen;
    logic [CntW-1:0] press_run;
    logic            press_ready;
    logic [CntW-1:0] tamper_run;
    logic            tamper_fired;
    logic [CntW-1:0] body_away_run;
    logic [CntW-1:0] body_near_run;
    logic            body_here;
    logic [CntW-1:0] scan_count;
    t_result         pending_events[$];
    int              errs = 0;

    function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
        return (v == {CntW{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic string field_name(input int i);
        case (i)
            0: return "door_event";
            1: return "door_now_open";
            2: return "unlock_event";
            3: return "tamper_event";
            4: return "body_event";
            5: return "body_present";
            6: return "light_update";
            default: return "light_on";
        endcase
    endfunction

    // Advances the predicted debounce state by one request and returns its events.
    task automatic predict_events(input logic cmd, input logic [7:0] samples,
                                  output t_result r);
        logic door_in;
        logic lock_in;
        logic tamp_in;
        logic body_in;
        logic photo_in;
        r = '0;
        {photo_in, body_in, tamp_in, lock_in, door_in} = samples[4:0];
        if (cmd == CMD_CLEAR) begin
            body_away_run = '0;
            body_near_run = '0;
            body_here = 1'b0;
            return;
        end

        scan_count = scan_count + 1'b1;
        if ((scan_count & LIGHT_MASK) == '0) begin
            r.light_update = 1'b1;
            r.light_on = photo_in;
        end

        if (door_in) begin
            door_shut_run = '0;
            door_ajar_run = bump(door_ajar_run);
            if (door_ajar_run >= thresholds.debounce_ticks) begin
                if (door_seen != DOOR_IS_OPEN) begin
                    r.door_event = 1'b1;
                    r.door_now_open = 1'b1;
                end
                door_seen = DOOR_IS_OPEN;
            end
        end else begin
            door_ajar_run = '0;
            door_shut_run = bump(door_shut_run);
            if (door_shut_run >= thresholds.debounce_ticks) begin
                if (door_seen != DOOR_IS_CLOSED) begin
                    r.door_event = 1'b1;
                    r.door_now_open = 1'b0;
                end
                door_seen = DOOR_IS_CLOSED;
            end
        end

        // A press fires only after the switch has been seen released.
        if (!lock_in) begin
            press_run = bump(press_run);
            if (press_run >= thresholds.debounce_ticks) begin
                if (press_ready) r.unlock_event = 1'b1;
                press_ready = 1'b0;
            end
        end else begin
            press_ready = 1'b1;
            press_run = '0;
        end

        if (!tamp_in) begin
            tamper_run = bump(tamper_run);
            if (tamper_run >= thresholds.debounce_ticks) begin
                if (!tamper_fired) r.tamper_event = 1'b1;
                tamper_fired = 1'b1;
            end
        end else begin
            tamper_fired = 1'b0;
            tamper_run = '0;
        end

        if (body_in) begin
            body_near_run = '0;
            body_away_run = bump(body_away_run);
            if (body_away_run >= thresholds.body_absent_ticks) begin
                if (body_here) r.body_event = 1'b1;
                body_here = 1'b0;
            end
        end else begin
            body_away_run = '0;
            body_near_run = bump(body_near_run);
            if (body_near_run >= thresholds.body_present_ticks) begin
                if (!body_here) begin
                    r.body_event = 1'b1;
                    r.body_present = 1'b1;
                end
                body_here = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result         want;
        t_result         got;
        logic [1:0]      reg_idx;
        logic [CntW-1:0] reg_val;
        string           bad;
        reg_idx = paddr[3:2];
        if (!i_rst_n) begin
            thresholds.debounce_ticks = DEBOUNCE_RST;
            thresholds.body_absent_ticks = BODY_ABSENT_RST;
            thresholds.body_present_ticks = BODY_PRESENT_RST;
            door_ajar_run = '0;
            door_shut_run = '0;
            door_seen = DOOR_UNKNOWN;
            press_run = '0;
            press_ready = 1'b0;
            tamper_run = '0;
            tamper_fired = 1'b0;
            body_away_run = '0;
            body_near_run = '0;
            body_here = 1'b0;
            scan_count = '0;
            pending_events.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (reg_idx)
                        REG_DEBOUNCE:     thresholds.debounce_ticks = pwdata[CntW-1:0];
                        REG_BODY_ABSENT:  thresholds.body_absent_ticks = pwdata[CntW-1:0];
                        REG_BODY_PRESENT: thresholds.body_present_ticks = pwdata[CntW-1:0];
                        default: ;
                    endcase
                end else if (reg_idx != REG_UNUSED) begin
                    case (reg_idx)
                        REG_DEBOUNCE:    reg_val = thresholds.debounce_ticks;
                        REG_BODY_ABSENT: reg_val = thresholds.body_absent_ticks;
                        default:         reg_val = thresholds.body_present_ticks;
                    endcase
                    if (prdata[CntW-1:0] !== reg_val) begin
                        errs++;
                        $display("%0t: register %0d read, expected %h got %h",
                                 $time, reg_idx, reg_val, prdata[CntW-1:0]);
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata);
                if (pending_events.size() == 0) begin
                    errs++;
                    $display("%0t: result %b with no request waiting, expected none",
                             $time, got);
                end else begin
                    want = pending_events.pop_front();
                    bad = "";
                    for (int i = 0; i < 8; i++)
                        if (got[i] !== want[i]) bad = {bad, " ", field_name(i)};
                    if (bad != "") begin
                        errs++;
                        $display("%0t: mismatch in%s, expected %b got %b",
                                 $time, bad, want, got);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                predict_events(s_axis_tuser, s_axis_tdata, want);
                pending_events.push_back(want);
            end
        end
        o_pending <= pending_events.size();
        o_err_count <= errs;
    end

endmodule

>>> tb/tb_multi_input_debounce_events_core.sv
// Top of the testbench for the multi-input debounce block: clock, reset, stimulus
// and verdict. Depends on mide_pkg, mide_tb_pkg, mide_event_checker and the RTL.
`timescale 1ns / 1ps
module tb_multi_input_debounce_events_core;
    import mide_pkg::*;
    import mide_tb_pkg::*;

    // Length of the receiver hold-off that forces the block to back up.
    localparam int HOLD_CYCLES = 40;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    int chk_errors;
    int chk_pending;

    // Percent of cycles in which the sender idles or the receiver stalls.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    // The stimulus bumps hold_seq to ask the receiver process for a hold-off.
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    multi_input_debounce_events_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mide_event_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_err_count   (chk_errors),
        .o_pending     (chk_pending)
    );

    // Receiver: random stalls, or a counted hold-off when the stimulus asks for one.
    // This is the only process that drives m_axis_tready.
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offers one request, after a random number of idle cycles, and returns at the
    // edge where it is taken. tvalid is lowered only when a gap is inserted, so a
    // request that follows straight on keeps tvalid high without a glitch.
    task automatic send_req(input logic cmd, input logic [4:0] samples);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {3'b000, samples};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // A scan request with the sampled levels given in field order.
    task automatic scan(input logic door, input logic lock, input logic tamp,
                        input logic body, input logic photo);
        send_req(CMD_SCAN, {photo, body, tamp, lock, door});
    endtask

    // Stops offering requests until every predicted result has been taken.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read(input logic [1:0] idx);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // The checker compares each read against its own copy of the thresholds.
    task automatic read_thresholds();
        reg_read(REG_DEBOUNCE);
        reg_read(REG_BODY_ABSENT);
        reg_read(REG_BODY_PRESENT);
    endtask

    // Thresholds change only with the block idle, i.e. with no result outstanding.
    // Every request yields a result, so nothing can still be in flight once drained.
    task automatic set_thresholds(input logic [7:0] deb, input logic [7:0] absent,
                                  input logic [7:0] present);
        wait_results_drained();
        reg_write(REG_DEBOUNCE, deb);
        reg_write(REG_BODY_ABSENT, absent);
        reg_write(REG_BODY_PRESENT, present);
        read_thresholds();
    endtask

    // Random traffic. Door, unlock, tamper and body levels are held for random run
    // lengths around the thresholds so that qualification is actually reached;
    // some requests are pure noise and some are clear commands. The photo level is
    // random on every tick. hold_at and pause_at name the request before which a
    // receiver hold-off starts or the sender waits for all results (-1 for none).
    task automatic run_phase(input int n_reqs, input int src_idle, input int sink_stall,
                             input int run_lo, input int run_hi, input int noise_pct,
                             input int clear_pct, input int hold_at, input int pause_at);
        logic [3:0] held;
        int         left [4];
        sink_stall_pct <= sink_stall;
        src_idle_pct = src_idle;
        held = 4'($urandom);
        for (int k = 0; k < 4; k++) left[k] = 0;
        for (int i = 0; i < n_reqs; i++) begin
            if (i == hold_at) hold_seq <= hold_seq + 1;
            if (i == pause_at) wait_results_drained();
            for (int k = 0; k < 4; k++) begin
                if (left[k] == 0) begin
                    held[k] = ~held[k];
                    left[k] = $urandom_range(run_hi, run_lo);
                end
                left[k]--;
            end
            if ($urandom_range(99) < clear_pct)
                send_req(CMD_CLEAR, 5'($urandom));
            else if ($urandom_range(99) < noise_pct)
                send_req(CMD_SCAN, 5'($urandom));
            else
                send_req(CMD_SCAN, {1'($urandom), held});
        end
    endtask

    initial begin : stimulus
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= CMD_SCAN;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Thresholds must read back their reset values.
        read_thresholds();

        // Directed part with reset thresholds (4, 12, 2).
        // The door starts unknown, so the fourth open sample reports an opening.
        // The unlock switch is held pressed from reset: it is not armed and stays quiet.
        scan(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        scan(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        scan(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        scan(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        // Release arms the unlock switch; two low body samples report presence.
        scan(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        scan(1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
        // The clear command drops body presence and gives an all-zero result.
        send_req(CMD_CLEAR, 5'b10101);
        // Door closes, unlock press qualifies, tamper fires once, no repeats after.
        repeat (5) scan(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);

        // A zero debounce threshold qualifies on the first sample of a level.
        set_thresholds(8'd0, BODY_ABSENT_RST, BODY_PRESENT_RST);
        // A write past the register map must leave the thresholds alone.
        reg_write(REG_UNUSED, 8'hff);
        read_thresholds();
        scan(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        scan(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        scan(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        send_req(CMD_CLEAR, 5'b01010);

        // Random phases: no idling, sender idling, receiver stalling, both.
        set_thresholds(DEBOUNCE_RST, BODY_ABSENT_RST, BODY_PRESENT_RST);
        run_phase(60, 0, 0, 1, 16, 10, 4, -1, -1);

        // Lowest thresholds; mid-phase the sender waits for every result.
        set_thresholds(8'd1, 8'd1, 8'd1);
        run_phase(60, 45, 0, 1, 4, 10, 4, -1, 30);

        // The receiver holds off for a long stretch while requests keep coming,
        // so the result register fills and the block must stall its input.
        set_thresholds(8'd3, 8'd5, 8'd2);
        run_phase(60, 0, 45, 1, 8, 10, 4, 20, -1);

        // Highest thresholds: levels held past 255 samples, so the run counters
        // saturate and still qualify.
        set_thresholds(8'd255, 8'd255, 8'd255);
        run_phase(270, 19, 19, 256, 300, 0, 0, -1, -1);

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (chk_errors == 0)
            $display("tb_multi_input_debounce_events_core OK");
        else
            $display("tb_multi_input_debounce_events_core NOT OK");
        $finish;
    end

    // Watchdog: stops a run that never finishes.
    initial begin
        #200000;
        $display("timeout with %0d results outstanding", chk_pending);
        $display("tb_multi_input_debounce_events_core NOT OK");
        $finish;
    end

endmodule
